### sv/bts_pkg.sv
`timescale 1ns / 1ps

package bts_pkg;

  // Field and fraction sizing
  localparam int FIELD_BITS      = 32;
  localparam int FRACTION_DIGITS = 3;
  localparam int FRAC_SCALE      = 10 ** FRACTION_DIGITS;
  localparam int FRAC_W          = $clog2(FRAC_SCALE);
  localparam int FDIG_W          = $clog2(FRACTION_DIGITS + 1);

  // Seconds total: hours*3600 + minutes*60 + seconds fits in 12 extra bits
  localparam int SECS_W = FIELD_BITS + 12;
  localparam int TOT_W  = SECS_W + FRAC_W;
  localparam int TS_W   = 54;
  localparam int CMP_W  = (TOT_W > TS_W) ? TOT_W : TS_W + 1;

  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int DEC_BASE     = 10;

  // Queue between the parser and the arithmetic pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  // Characters
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_OPEN   = 3'd1,
    ST_NO_NUMBER = 3'd2,
    ST_NO_COLON  = 3'd3,
    ST_NO_CLOSE  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_start;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [TS_W-1:0] timestamp_ms;
    status_t         status;
  } out_item_t;

  // One parsed line: either a finished timestamp or an error status
  typedef struct packed {
    logic                  fin;
    status_t               status;
    logic [FIELD_BITS-1:0] hours;
    logic [FIELD_BITS-1:0] minutes;
    logic [FIELD_BITS-1:0] seconds;
    logic [FRAC_W-1:0]     frac;
    logic [FDIG_W-1:0]     fdig;
  } q_entry_t;

  // Pad a short fraction: 10 ** (FRACTION_DIGITS - digits)
  function automatic logic [FRAC_W:0] frac_scale(input logic [FDIG_W-1:0] d);
    int s;
    s = 1;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      if (i >= int'(d)) s = s * DEC_BASE;
    end
    return (FRAC_W + 1)'(s);
  endfunction

endpackage

### sv/bts_front.sv
`timescale 1ns / 1ps

module bts_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  bts_pkg::in_item_t  byte_item,
  input  logic               q_full,
  output logic               push,
  output bts_pkg::q_entry_t  push_data
);

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_HOURS,
    PH_MINUTES,
    PH_SECONDS,
    PH_FRACTION,
    PH_DONE
  } phase_t;

  localparam int AW = bts_pkg::FIELD_BITS + 4;

  phase_t                          phase, phase_next, ph_cur;
  logic [bts_pkg::FIELD_BITS-1:0]  acc, acc_next;
  logic                            seen, seen_next;
  logic [bts_pkg::FIELD_BITS-1:0]  hours, hours_next;
  logic [bts_pkg::FIELD_BITS-1:0]  minutes, minutes_next;
  logic [bts_pkg::FRAC_W-1:0]      frac, frac_next;
  logic [bts_pkg::FDIG_W-1:0]      fdig, fdig_next;

  logic                            take, emit, fin;
  bts_pkg::status_t                est;
  logic [7:0]                      c;
  logic                            is_dec, is_space;
  logic [AW-1:0]                   acc_x10;
  logic                            acc_ovf;
  logic [bts_pkg::FRAC_W+3:0]      frac_x10;

  assign byte_stall = q_full;
  assign take       = byte_valid && !byte_stall;
  assign c          = byte_item.data_byte;

  // Character classes and digit accumulators
  assign is_dec   = (c >= bts_pkg::CH_ZERO) && (c <= bts_pkg::CH_NINE);
  assign is_space = (c == bts_pkg::CH_SPACE) ||
                    ((c >= bts_pkg::CH_TAB) && (c <= bts_pkg::CH_CR));
  assign acc_x10  = AW'(acc) * AW'(bts_pkg::DEC_BASE) + AW'(c[3:0]);
  assign acc_ovf  = |acc_x10[AW-1:bts_pkg::FIELD_BITS];
  assign frac_x10 = (bts_pkg::FRAC_W + 4)'(frac) * (bts_pkg::FRAC_W + 4)'(bts_pkg::DEC_BASE)
                  + (bts_pkg::FRAC_W + 4)'(c[3:0]);

  // Parse one byte
  always_comb begin
    ph_cur       = byte_item.line_start ? PH_OPEN : phase;
    phase_next   = ph_cur;
    acc_next     = acc;
    seen_next    = seen;
    hours_next   = hours;
    minutes_next = minutes;
    frac_next    = frac;
    fdig_next    = fdig;
    emit         = 1'b0;
    fin          = 1'b0;
    est          = bts_pkg::ST_OK;

    unique case (ph_cur)
      PH_OPEN: begin
        if (c == bts_pkg::CH_OPEN) begin
          phase_next = PH_HOURS;
          acc_next   = '0;
          seen_next  = 1'b0;
          // a stamp without a fraction closes with fraction zero
          frac_next  = '0;
          fdig_next  = '0;
        end else if (!is_space) begin
          emit = 1'b1;
          est  = bts_pkg::ST_NO_OPEN;
        end
      end
      PH_HOURS, PH_MINUTES, PH_SECONDS: begin
        if (is_dec) begin
          acc_next  = acc_x10[bts_pkg::FIELD_BITS-1:0];
          seen_next = 1'b1;
          if (acc_ovf) begin
            emit = 1'b1;
            est  = bts_pkg::ST_OVERFLOW;
          end
        end else if (!seen) begin
          emit = 1'b1;
          est  = bts_pkg::ST_NO_NUMBER;
        end else if (ph_cur == PH_SECONDS) begin
          if (c == bts_pkg::CH_DOT) begin
            phase_next = PH_FRACTION;
            frac_next  = '0;
            fdig_next  = '0;
          end else if (c == bts_pkg::CH_CLOSE) begin
            fin = 1'b1;
          end else begin
            emit = 1'b1;
            est  = bts_pkg::ST_NO_CLOSE;
          end
        end else if (c != bts_pkg::CH_COLON) begin
          emit = 1'b1;
          est  = bts_pkg::ST_NO_COLON;
        end else begin
          if (ph_cur == PH_HOURS) begin
            hours_next = acc;
            phase_next = PH_MINUTES;
          end else begin
            minutes_next = acc;
            phase_next   = PH_SECONDS;
          end
          acc_next  = '0;
          seen_next = 1'b0;
        end
      end
      PH_FRACTION: begin
        if (is_dec) begin
          if (int'(fdig) < bts_pkg::FRACTION_DIGITS) begin
            frac_next = frac_x10[bts_pkg::FRAC_W-1:0];
            fdig_next = fdig + 1'b1;
          end
        end else if (c == bts_pkg::CH_CLOSE) begin
          fin = 1'b1;
        end else begin
          emit = 1'b1;
          est  = bts_pkg::ST_NO_CLOSE;
        end
      end
      PH_DONE: begin
      end
    endcase

    // Line ended before a result: report what was expected next
    if (!emit && !fin && byte_item.line_end) begin
      unique case (phase_next)
        PH_OPEN: begin
          emit = 1'b1;
          est  = bts_pkg::ST_NO_OPEN;
        end
        PH_HOURS, PH_MINUTES: begin
          emit = 1'b1;
          est  = seen_next ? bts_pkg::ST_NO_COLON : bts_pkg::ST_NO_NUMBER;
        end
        PH_SECONDS: begin
          emit = 1'b1;
          est  = seen_next ? bts_pkg::ST_NO_CLOSE : bts_pkg::ST_NO_NUMBER;
        end
        PH_FRACTION: begin
          emit = 1'b1;
          est  = bts_pkg::ST_NO_CLOSE;
        end
        PH_DONE: begin
        end
      endcase
    end

    if (emit || fin) phase_next = PH_DONE;
  end

  // Request toward the arithmetic side
  assign push              = take && (emit || fin);
  assign push_data.fin     = fin;
  assign push_data.status  = est;
  assign push_data.hours   = hours;
  assign push_data.minutes = minutes;
  assign push_data.seconds = acc;
  assign push_data.frac    = frac;
  assign push_data.fdig    = fdig;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_OPEN;
      acc     <= '0;
      seen    <= 1'b0;
      hours   <= '0;
      minutes <= '0;
      frac    <= '0;
      fdig    <= '0;
    end else if (take) begin
      phase   <= phase_next;
      acc     <= acc_next;
      seen    <= seen_next;
      hours   <= hours_next;
      minutes <= minutes_next;
      frac    <= frac_next;
      fdig    <= fdig_next;
    end
  end

  // Every result closes the line
  a_done_after_push: assert property (@(posedge clk) disable iff (rst)
    push |=> (phase == PH_DONE))
    else $error("parser not idle after issuing a result");

endmodule

### sv/bts_queue.sv
`timescale 1ns / 1ps

module bts_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bts_pkg::q_entry_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              avail,
  output bts_pkg::q_entry_t head
);

  bts_pkg::q_entry_t        slots [bts_pkg::QUEUE_DEPTH];
  logic [bts_pkg::QA_W-1:0] wr_ptr, rd_ptr;
  logic [bts_pkg::QA_W:0]   count;

  assign full  = (count == (bts_pkg::QA_W + 1)'(bts_pkg::QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (bts_pkg::QA_W + 1)'(push) - (bts_pkg::QA_W + 1)'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("request popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (bts_pkg::QA_W + 1)'(bts_pkg::QUEUE_DEPTH))
    else $error("queue fill level out of range");

endmodule

### sv/bts_back.sv
`timescale 1ns / 1ps

module bts_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  bts_pkg::q_entry_t  head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output bts_pkg::out_item_t result_item
);

  localparam int FW = bts_pkg::FRAC_W;
  localparam int SW = bts_pkg::SECS_W;
  localparam int TW = bts_pkg::TOT_W;
  localparam int CW = bts_pkg::CMP_W;

  localparam logic [bts_pkg::TS_W-1:0] TOTAL_MAX = '1;

  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;

  // Stage 1: constant products and fraction padding
  logic             s1_fin;
  bts_pkg::status_t s1_status;
  logic [SW-1:0]    s1_h, s1_m, s1_s;
  logic [FW-1:0]    s1_fpad;
  // Stage 2: whole seconds
  logic             s2_fin;
  bts_pkg::status_t s2_status;
  logic [SW-1:0]    s2_secs;
  logic [FW-1:0]    s2_fpad;
  // Stage 3: scaled total
  logic             s3_fin;
  bts_pkg::status_t s3_status;
  logic [TW-1:0]    s3_total;

  logic [2*FW:0]    fpad_prod;
  logic [CW-1:0]    total_ext;
  logic             ovf;

  // Pipeline advance
  assign ld4 = !v4 || !result_stall;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign pop = avail && ld1;

  assign fpad_prod = (2 * FW + 1)'(head.frac) * (2 * FW + 1)'(bts_pkg::frac_scale(head.fdig));
  assign total_ext = CW'(s3_total);
  assign ovf       = total_ext > CW'(TOTAL_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= pop;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_fin    <= head.fin;
      s1_status <= head.status;
      s1_h      <= SW'(head.hours) * SW'(bts_pkg::SEC_PER_HOUR);
      s1_m      <= SW'(head.minutes) * SW'(bts_pkg::SEC_PER_MIN);
      s1_s      <= SW'(head.seconds);
      s1_fpad   <= fpad_prod[FW-1:0];
    end
    if (ld2) begin
      s2_fin    <= s1_fin;
      s2_status <= s1_status;
      s2_secs   <= s1_h + s1_m + s1_s;
      s2_fpad   <= s1_fpad;
    end
    if (ld3) begin
      s3_fin    <= s2_fin;
      s3_status <= s2_status;
      s3_total  <= TW'(s2_secs) * TW'(bts_pkg::FRAC_SCALE) + TW'(s2_fpad);
    end
    // Output register: range check and status merge
    if (ld4) begin
      if (s3_fin) begin
        result_item.status       <= ovf ? bts_pkg::ST_OVERFLOW : bts_pkg::ST_OK;
        result_item.timestamp_ms <= ovf ? '0 : total_ext[bts_pkg::TS_W-1:0];
      end else begin
        result_item.status       <= s3_status;
        result_item.timestamp_ms <= '0;
      end
    end
  end

  assign result_valid = v4;

endmodule

### sv/bracket_timestamp_parser.sv
`timescale 1ns / 1ps
// Throughput: one byte per cycle, sustained, while results are taken.
// A result is offered once the byte that ends the timestamp has passed through the queue write
//   and then a four-stage arithmetic pipeline; the last stage is the output register.
// A four-entry request queue decouples the parser from the pipeline; bytes stall only when it is full.
// Reset (rst, synchronous, active high) returns the parser to waiting for '[' and empties
//   the queue and pipeline at once; no clearing pass.
module bracket_timestamp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  bts_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_stall,
  output bts_pkg::out_item_t result_item
);

  logic              push, pop, q_full, q_avail;
  bts_pkg::q_entry_t push_data, q_head;

  bts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  bts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .avail     (q_avail),
    .head      (q_head)
  );

  bts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (q_avail),
    .head         (q_head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 1600;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << bts_pkg::TS_W) - 64'd1;
  localparam logic [63:0] FIELD_MAX = (64'd1 << bts_pkg::FIELD_BITS) - 64'd1;

  typedef enum logic [2:0] {
    P_OPEN,
    P_HOURS,
    P_MINUTES,
    P_SECONDS,
    P_FRACTION,
    P_DONE
  } parse_step_t;

  // Timestamp scoreboard: tracks the parse of the current line and holds the
  // results that the accepted bytes should produce, oldest first
  class stamp_scoreboard;
    parse_step_t        step;
    logic [63:0]        field_acc;
    bit                 field_has_digit;
    logic [63:0]        hours_val;
    logic [63:0]        minutes_val;
    logic [63:0]        frac_acc;
    int                 frac_count;
    bts_pkg::out_item_t stamps_due[$];
    int                 mismatches;
    int                 by_status[8];

    function new();
      clear_line();
      mismatches = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void clear_line();
      step            = P_OPEN;
      field_acc       = '0;
      field_has_digit = 1'b0;
      hours_val       = '0;
      minutes_val     = '0;
      frac_acc        = '0;
      frac_count      = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit is_num(logic [7:0] c);
      return c >= bts_pkg::CH_ZERO && c <= bts_pkg::CH_NINE;
    endfunction

    // Close bracket: seconds total scaled by the fraction, overflow flagged
    function void close_stamp(output bts_pkg::status_t st, output logic [63:0] ms);
      logic [63:0] scale;
      logic [63:0] frac;
      logic [63:0] secs;
      logic [63:0] limit;
      scale = 64'd1;
      frac  = frac_acc;
      for (int i = 0; i < bts_pkg::FRACTION_DIGITS; i++) begin
        scale = scale * bts_pkg::DEC_BASE;
        if (i >= frac_count) frac = frac * bts_pkg::DEC_BASE;
      end
      secs  = hours_val * bts_pkg::SEC_PER_HOUR + minutes_val * bts_pkg::SEC_PER_MIN
            + field_acc;
      limit = (TOTAL_MAX - frac) / scale;
      if (secs > limit) begin
        st = bts_pkg::ST_OVERFLOW;
        ms = '0;
      end else begin
        st = bts_pkg::ST_OK;
        ms = secs * scale + frac;
      end
    endfunction

    // Accepted request: advance the parse and note any result it causes
    function void note_request(bts_pkg::in_item_t it);
      logic [7:0]         c;
      bit                 got;
      bts_pkg::status_t   st;
      logic [63:0]        ms;
      bts_pkg::out_item_t res;
      c   = it.data_byte;
      got = 1'b0;
      st  = bts_pkg::ST_OK;
      ms  = '0;
      if (it.line_start) clear_line();
      case (step)
        P_OPEN: begin
          if (is_blank(c)) begin
          end else if (c == bts_pkg::CH_OPEN) begin
            step            = P_HOURS;
            field_acc       = '0;
            field_has_digit = 1'b0;
          end else begin
            got = 1'b1;
            st  = bts_pkg::ST_NO_OPEN;
          end
        end
        P_HOURS, P_MINUTES, P_SECONDS: begin
          if (is_num(c)) begin
            field_acc       = field_acc * bts_pkg::DEC_BASE + 64'(c - bts_pkg::CH_ZERO);
            field_has_digit = 1'b1;
            if (field_acc > FIELD_MAX) begin
              got = 1'b1;
              st  = bts_pkg::ST_OVERFLOW;
            end
          end else if (!field_has_digit) begin
            got = 1'b1;
            st  = bts_pkg::ST_NO_NUMBER;
          end else if (step == P_SECONDS) begin
            if (c == bts_pkg::CH_DOT) begin
              step       = P_FRACTION;
              frac_acc   = '0;
              frac_count = 0;
            end else if (c == bts_pkg::CH_CLOSE) begin
              got = 1'b1;
              close_stamp(st, ms);
            end else begin
              got = 1'b1;
              st  = bts_pkg::ST_NO_CLOSE;
            end
          end else if (c != bts_pkg::CH_COLON) begin
            got = 1'b1;
            st  = bts_pkg::ST_NO_COLON;
          end else begin
            if (step == P_HOURS) hours_val = field_acc;
            else minutes_val = field_acc;
            step            = (step == P_HOURS) ? P_MINUTES : P_SECONDS;
            field_acc       = '0;
            field_has_digit = 1'b0;
          end
        end
        P_FRACTION: begin
          if (is_num(c)) begin
            // digits past the kept precision are dropped
            if (frac_count < bts_pkg::FRACTION_DIGITS) begin
              frac_acc   = frac_acc * bts_pkg::DEC_BASE + 64'(c - bts_pkg::CH_ZERO);
              frac_count = frac_count + 1;
            end
          end else if (c == bts_pkg::CH_CLOSE) begin
            got = 1'b1;
            close_stamp(st, ms);
          end else begin
            got = 1'b1;
            st  = bts_pkg::ST_NO_CLOSE;
          end
        end
        default: begin
        end
      endcase

      // Line ended early: report what the next byte was missing
      if (!got && it.line_end && step != P_DONE) begin
        got = 1'b1;
        case (step)
          P_OPEN:             st = bts_pkg::ST_NO_OPEN;
          P_HOURS, P_MINUTES: st = field_has_digit ? bts_pkg::ST_NO_COLON
                                                   : bts_pkg::ST_NO_NUMBER;
          P_SECONDS:          st = field_has_digit ? bts_pkg::ST_NO_CLOSE
                                                   : bts_pkg::ST_NO_NUMBER;
          default:            st = bts_pkg::ST_NO_CLOSE;
        endcase
      end

      if (got) begin
        step             = P_DONE;
        res.status       = st;
        res.timestamp_ms = (st == bts_pkg::ST_OK) ? ms[bts_pkg::TS_W-1:0] : '0;
        stamps_due.push_back(res);
      end
    endfunction

    function void check_result(bts_pkg::out_item_t act);
      bts_pkg::out_item_t want;
      if (stamps_due.size() == 0) begin
        $error("unexpected result: timestamp_ms %0d status %0d",
               act.timestamp_ms, act.status);
        mismatches++;
        return;
      end
      want = stamps_due.pop_front();
      by_status[want.status]++;
      if (act.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, act.status);
        mismatches++;
      end
      if (act.timestamp_ms !== want.timestamp_ms) begin
        $error("timestamp_ms: expected %0d, actual %0d",
               want.timestamp_ms, act.timestamp_ms);
        mismatches++;
      end
    endfunction

    function int pending();
      return stamps_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  bts_pkg::in_item_t  byte_item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  bts_pkg::out_item_t result_item;

  stamp_scoreboard sb = new();

  int send_idle_pct = 29;
  int recv_idle_pct = 46;
  int bytes_sent = 0;
  int lines_sent = 0;

  bracket_timestamp_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: check accepted results, then pick next cycle's stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_item);
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // One request: optional idle cycles, then hold until accepted
  task automatic send_byte(input bts_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.note_request(it);
    bytes_sent++;
  endtask

  task automatic send_line(input string s, input bit start, input bit last);
    bts_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.data_byte  = s[i];
      it.line_start = start && (i == 0);
      it.line_end   = last && (i == s.len() - 1);
      send_byte(it);
    end
    lines_sent++;
  endtask

  // Raw bytes with random flags, zero byte included
  task automatic send_noise();
    bts_pkg::in_item_t it;
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      it.data_byte  = 8'($urandom_range(0, 255));
      it.line_start = ($urandom_range(0, 3) == 0);
      it.line_end   = ($urandom_range(0, 3) == 0);
      send_byte(it);
    end
  endtask

  // Decimal field: mostly small, some near and past the 32-bit limit
  function automatic string rand_field();
    int          k;
    logic [63:0] v;
    string       s;
    k = $urandom_range(0, 99);
    if (k < 3) return "";
    if (k < 60) v = $urandom_range(0, 99);
    else if (k < 78) v = {32'd0, $urandom};
    else if (k < 90) v = 64'd4294967294 + $urandom_range(0, 3);
    else v = {30'd0, 2'($urandom_range(0, 3)), $urandom};
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) s = {"0", s};
    end
    return s;
  endfunction

  // Mostly well-formed lines with random content; some corrupted or cut short
  task automatic send_random_line();
    string s;
    string pad;
    int    k;
    int    idx;
    bit    start;
    bit    last;
    logic [7:0] blanks [6];
    logic [7:0] specials [8];
    blanks   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    specials = '{bts_pkg::CH_OPEN, bts_pkg::CH_CLOSE, bts_pkg::CH_COLON, bts_pkg::CH_DOT,
                 bts_pkg::CH_ZERO, bts_pkg::CH_NINE, 8'h20, 8'h41};
    s = "";
    for (int i = $urandom_range(0, 3) - 1; i > 0; i--) begin
      pad = " ";
      pad[0] = blanks[$urandom_range(0, 5)];
      s = {s, pad};
    end
    s = {s, "[", rand_field(), ":", rand_field(), ":", rand_field()};
    if ($urandom_range(0, 9) < 4) begin
      s = {s, "."};
      for (int i = $urandom_range(0, 5); i > 0; i--)
        s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    s = {s, "]"};
    // trailing text after the stamp is ignored
    if ($urandom_range(0, 9) < 3) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) begin
        pad = " ";
        pad[0] = 8'($urandom_range(32, 126));
        s = {s, pad};
      end
    end
    start = ($urandom_range(0, 19) != 0);
    last  = 1'b1;
    k = $urandom_range(0, 99);
    if (k >= 60 && k < 75) begin
      idx = $urandom_range(0, s.len() - 1);
      if ($urandom_range(0, 1) == 0) s[idx] = specials[$urandom_range(0, 7)];
      else s[idx] = 8'($urandom_range(1, 255));
    end else if (k >= 75 && k < 90) begin
      s = s.substr(0, $urandom_range(0, s.len() - 2));
    end else if (k >= 90) begin
      last = 1'b0;
    end
    send_line(s, start, last);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: no line start after reset with extra fraction digits,
    // ignored byte after a result, blanks and an empty fraction,
    // a line that ends right after the bracket, a missing bracket
    send_line("[1:2:3.4567]", 1'b0, 1'b1);
    send_line("z", 1'b0, 1'b1);
    send_line("\t[0:0:0.]", 1'b1, 1'b1);
    send_line("[", 1'b1, 1'b1);
    send_line("q", 1'b1, 1'b1);

    while (bytes_sent < RANDOM_ITEMS + 24) begin
      if (send_idle_pct == 29 && bytes_sent > RANDOM_ITEMS / 3) begin
        // sender holds off until every result is back
        byte_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        send_idle_pct = 46;
        recv_idle_pct = 29;
      end else if (send_idle_pct == 46 && bytes_sent > 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < 85) send_random_line();
      else send_noise();
    end
    byte_valid <= 1'b0;

    wait_drained();
    repeat (12) @(posedge clk);

    $display("Sent %0d bytes in %0d lines; results ok %0d, overflow %0d, other errors %0d",
             bytes_sent, lines_sent, sb.by_status[bts_pkg::ST_OK],
             sb.by_status[bts_pkg::ST_OVERFLOW],
             sb.by_status[bts_pkg::ST_NO_OPEN] + sb.by_status[bts_pkg::ST_NO_NUMBER]
             + sb.by_status[bts_pkg::ST_NO_COLON] + sb.by_status[bts_pkg::ST_NO_CLOSE]);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
